>>> rtl/pffl_pkg.sv
// ----------------------------------------------------------------------------
// pffl_pkg: shared types and constants of the page frame allocator
// Holds sizes, command and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pffl_pkg;

  // sizes
  localparam int NumPages = 64;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int AddrW    = 32;
  localparam int ShiftW   = 5;

  localparam logic [ShiftW-1:0] PageShiftReset = ShiftW'(21);

  // input command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register indexes
  localparam logic REG_MEMORY_BASE = 1'b0;
  localparam logic REG_PAGE_SHIFT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_REFUSE,
    ST_FREE_LINK,
    ST_FREE_TAIL
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic start_alloc;
    logic close_group;
    logic emit_alloc;
    logic emit_refuse;
    logic free_new;
    logic rd_tail;
    logic wr_pidx_link;
    logic wr_tail_link;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic refuse;
    logic in_range;
    logic group_open;
    logic out_free;
    logic rem_last;
  } dp_status_t;

endpackage

>>> rtl/page_frame_free_list_allocator.sv
// Allocate of n pages: after accept and a decode state, one frame per cycle
//   enters the output register while the output is not stalled.
// Refused allocate: decode, then a refusal result. Free: decode only at
//   group start, else a read and two writes via the link memory write port.
// Reset: all frames free in ascending order; unwritten link entries are
//   served from per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator: free list of page frames
// Hands out frames from the head of a linked free list and pushes freed
// groups back in front of it, with a saturating free counter.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [pffl_pkg::AddrW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [pffl_pkg::CntW-1:0]      page_count_i,
  input  logic [pffl_pkg::IdxW-1:0]      page_index_i,
  input  logic                           last_in_group_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ok_o,
  output logic [pffl_pkg::IdxW-1:0]      frame_index_o,
  output logic [pffl_pkg::AddrW-1:0]     frame_addr_o,
  output logic                           last_page_o
);

  pffl_pkg::ctrl_cmd_t  ctrl_cmd;
  pffl_pkg::dp_status_t dp_status;

  // sequencer
  pffl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // list storage and result register
  pffl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .status_o        (dp_status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_in_i        (cmd_i),
    .page_count_i    (page_count_i),
    .page_index_i    (page_index_i),
    .last_in_group_i (last_in_group_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .frame_index_o   (frame_index_o),
    .frame_addr_o    (frame_addr_o),
    .last_page_o     (last_page_o)
  );

endmodule

>>> rtl/pffl_datapath.sv
// ----------------------------------------------------------------------------
// pffl_datapath: link memory, free list registers and result register
// Keeps the next-link table, list head, free count, open group state,
// configuration registers and the registered output channel.
// ----------------------------------------------------------------------------
module pffl_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pffl_pkg::ctrl_cmd_t            cmd_i,
  output pffl_pkg::dp_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [pffl_pkg::AddrW-1:0]     cfg_data_i,
  input  logic                           cmd_in_i,
  input  logic [pffl_pkg::CntW-1:0]      page_count_i,
  input  logic [pffl_pkg::IdxW-1:0]      page_index_i,
  input  logic                           last_in_group_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ok_o,
  output logic [pffl_pkg::IdxW-1:0]      frame_index_o,
  output logic [pffl_pkg::AddrW-1:0]     frame_addr_o,
  output logic                           last_page_o
);

  // configuration
  logic [pffl_pkg::AddrW-1:0]  mem_base_q;
  logic [pffl_pkg::ShiftW-1:0] page_shift_q;

  // latched item
  logic                        cmd_q;
  logic [pffl_pkg::CntW-1:0]   count_q;
  logic [pffl_pkg::IdxW-1:0]   pidx_q;
  logic                        last_q;

  // list state
  logic [pffl_pkg::IdxW-1:0]   head_q, head_d, head_eff;
  logic                        pend_q, pend_d;
  logic [pffl_pkg::CntW-1:0]   free_count_q, free_count_d;
  logic [pffl_pkg::IdxW-1:0]   tail_q, tail_d;
  logic                        open_q, open_d;
  logic [pffl_pkg::CntW-1:0]   rem_q, rem_d;

  // link memory
  logic [pffl_pkg::IdxW-1:0]   link_mem [pffl_pkg::NumPages];
  logic [pffl_pkg::NumPages-1:0] link_vld_q;
  logic [pffl_pkg::IdxW-1:0]   rd_data_q, rd_addr_q, link_rd;
  logic                        rd_valid_q;
  logic                        mem_we, mem_re;
  logic [pffl_pkg::IdxW-1:0]   mem_waddr, mem_wdata, mem_raddr;

  // output register
  logic                        out_valid_q;
  logic                        ok_q, last_page_q;
  logic [pffl_pkg::IdxW-1:0]   frame_index_q;
  logic [pffl_pkg::AddrW-1:0]  frame_addr_q;
  logic                        out_load;
  logic [pffl_pkg::AddrW-1:0]  alloc_addr;

  // unwritten entries read as their reset link
  assign link_rd  = rd_valid_q ? rd_data_q : rd_addr_q + pffl_pkg::IdxW'(1);
  // after a walk step the head comes from the registered link read
  assign head_eff = pend_q ? link_rd : head_q;

  assign alloc_addr = mem_base_q
                    + ({{(pffl_pkg::AddrW-pffl_pkg::IdxW){1'b0}}, head_eff} << page_shift_q);

  // status to controller
  assign out_load = cmd_i.emit_alloc | cmd_i.emit_refuse;
  always_comb begin
    status_o.is_free    = (cmd_q == pffl_pkg::CMD_FREE);
    status_o.refuse     = (count_q == '0) || (count_q > free_count_q);
    status_o.in_range   = ({1'b0, pidx_q} < pffl_pkg::CntW'(pffl_pkg::NumPages));
    status_o.group_open = open_q;
    status_o.out_free   = !out_valid_q || !out_stall_i;
    status_o.rem_last   = (rem_q == pffl_pkg::CntW'(1));
  end

  // memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = head_eff;
    mem_re    = 1'b0;
    mem_raddr = head_eff;
    if (cmd_i.free_new) begin
      mem_we = 1'b1;
    end
    if (cmd_i.wr_pidx_link) begin
      mem_we    = 1'b1;
      mem_wdata = link_rd;
    end
    if (cmd_i.wr_tail_link) begin
      mem_we    = 1'b1;
      mem_waddr = tail_q;
      mem_wdata = pidx_q;
    end
    if (cmd_i.emit_alloc) begin
      mem_re = 1'b1;
    end
    if (cmd_i.rd_tail) begin
      mem_re    = 1'b1;
      mem_raddr = tail_q;
    end
  end

  // list state next values
  always_comb begin
    head_d       = head_eff;
    pend_d       = cmd_i.emit_alloc;
    free_count_d = free_count_q;
    tail_d       = tail_q;
    open_d       = open_q;
    rem_d        = rem_q;
    if (cmd_i.close_group) begin
      open_d = 1'b0;
    end
    if (cmd_i.start_alloc) begin
      rem_d        = count_q;
      free_count_d = free_count_q - count_q;
    end
    if (cmd_i.emit_alloc) begin
      rem_d = rem_q - pffl_pkg::CntW'(1);
    end
    if (cmd_i.free_new) begin
      head_d = pidx_q;
      tail_d = pidx_q;
      open_d = !last_q;
    end
    if (cmd_i.wr_tail_link) begin
      tail_d = pidx_q;
      if (last_q) begin
        open_d = 1'b0;
      end
    end
    // count a returned frame, saturate at the table size
    if ((cmd_i.free_new || cmd_i.wr_tail_link) &&
        (free_count_q < pffl_pkg::CntW'(pffl_pkg::NumPages))) begin
      free_count_d = free_count_q + pffl_pkg::CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_base_q   <= '0;
      page_shift_q <= pffl_pkg::PageShiftReset;
      head_q       <= '0;
      pend_q       <= 1'b0;
      free_count_q <= pffl_pkg::CntW'(pffl_pkg::NumPages);
      tail_q       <= '0;
      open_q       <= 1'b0;
      rem_q        <= '0;
      link_vld_q   <= '0;
      rd_valid_q   <= 1'b0;
      rd_addr_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pffl_pkg::REG_MEMORY_BASE: mem_base_q   <= cfg_data_i;
          pffl_pkg::REG_PAGE_SHIFT:  page_shift_q <= cfg_data_i[pffl_pkg::ShiftW-1:0];
          default: ;
        endcase
      end
      head_q       <= head_d;
      pend_q       <= pend_d;
      free_count_q <= free_count_d;
      tail_q       <= tail_d;
      open_q       <= open_d;
      rem_q        <= rem_d;
      if (mem_we) begin
        link_vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_q <= link_vld_q[mem_raddr];
        rd_addr_q  <= mem_raddr;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // link memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= link_mem[mem_raddr];
    end
  end

  // hold the accepted request and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      cmd_q   <= cmd_in_i;
      count_q <= page_count_i;
      pidx_q  <= page_index_i;
      last_q  <= last_in_group_i;
    end
    if (cmd_i.emit_alloc) begin
      ok_q          <= 1'b1;
      frame_index_q <= head_eff;
      frame_addr_q  <= alloc_addr;
      last_page_q   <= status_o.rem_last;
    end else if (cmd_i.emit_refuse) begin
      ok_q          <= 1'b0;
      frame_index_q <= '0;
      frame_addr_q  <= '0;
      last_page_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign frame_index_o = frame_index_q;
  assign frame_addr_o  = frame_addr_q;
  assign last_page_o   = last_page_q;

endmodule

>>> rtl/pffl_ctrl.sv
// ----------------------------------------------------------------------------
// pffl_ctrl: sequencer of the page frame allocator
// Accepts one request at a time and steps the datapath through an
// allocate walk, a refusal or the linking of a freed frame.
// ----------------------------------------------------------------------------
module pffl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pffl_pkg::dp_status_t  status_i,
  output pffl_pkg::ctrl_cmd_t   cmd_o
);

  pffl_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pffl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pffl_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pffl_pkg::ST_DECODE;
      end
      pffl_pkg::ST_DECODE: begin
        if (!status_i.is_free) begin
          state_d = status_i.refuse ? pffl_pkg::ST_REFUSE : pffl_pkg::ST_ALLOC;
        end else if (status_i.in_range && status_i.group_open) begin
          state_d = pffl_pkg::ST_FREE_LINK;
        end else begin
          state_d = pffl_pkg::ST_IDLE;
        end
      end
      pffl_pkg::ST_ALLOC: begin
        if (status_i.out_free && status_i.rem_last) state_d = pffl_pkg::ST_IDLE;
      end
      pffl_pkg::ST_REFUSE: begin
        if (status_i.out_free) state_d = pffl_pkg::ST_IDLE;
      end
      pffl_pkg::ST_FREE_LINK: state_d = pffl_pkg::ST_FREE_TAIL;
      pffl_pkg::ST_FREE_TAIL: state_d = pffl_pkg::ST_IDLE;
      default:                state_d = pffl_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pffl_pkg::ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.latch_item = in_valid_i;
      end
      pffl_pkg::ST_DECODE: begin
        if (!status_i.is_free) begin
          cmd_o.close_group = 1'b1;
          cmd_o.start_alloc = !status_i.refuse;
        end else if (status_i.in_range) begin
          cmd_o.free_new = !status_i.group_open;
          cmd_o.rd_tail  = status_i.group_open;
        end
      end
      pffl_pkg::ST_ALLOC:     cmd_o.emit_alloc   = status_i.out_free;
      pffl_pkg::ST_REFUSE:    cmd_o.emit_refuse  = status_i.out_free;
      pffl_pkg::ST_FREE_LINK: cmd_o.wr_pidx_link = 1'b1;
      pffl_pkg::ST_FREE_TAIL: cmd_o.wr_tail_link = 1'b1;
      default: ;
    endcase
  end

endmodule
